// ----- hdl/ssp_pkg.sv -----
// Shared types and constants for the smallest string period block.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int MAX_LEN  = 128;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W   = 8;
    localparam int PERIOD_W = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } t_ssp_in;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                overflow;
    } t_ssp_out;

    // controller to datapath
    typedef struct packed {
        logic load;      // store accepted byte
        logic k_init;    // k = 1
        logic k_inc;     // next candidate period
        logic rem_load;  // rem = n
        logic rem_sub;   // rem -= k
        logic i_load;    // i = k
        logic rd_issue;  // read s[i], s[i-k], i++
        logic emit;      // present k and overflow, clear string state
    } t_ssp_cmd;

    // datapath to controller
    typedef struct packed {
        logic k_lt_n;
        logic rem_gt_k;
        logic rem_eq_k;
        logic i_lt_n;
        logic mismatch;
    } t_ssp_sts;

endpackage

`default_nettype wire

// ----- hdl/ssp_datapath.sv -----
// Datapath: character store, length and overflow state, period search counters.
`timescale 1ns / 1ps
`default_nettype none

module ssp_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssp_pkg::t_ssp_in  i_req,
    input  wire ssp_pkg::t_ssp_cmd i_cmd,
    output ssp_pkg::t_ssp_sts      o_sts,
    output logic                   o_valid,
    output ssp_pkg::t_ssp_out      o_result
);
    import ssp_pkg::*;

    logic [CHAR_W-1:0] r_mem [MAX_LEN];

    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    logic [LEN_W-1:0]  r_k;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_i;
    logic [CHAR_W-1:0] r_rd_a;
    logic [CHAR_W-1:0] r_rd_b;
    logic              r_cmp_vld;
    logic              r_out_vld;
    t_ssp_out          r_result;

    logic              len_full;
    logic [LEN_W-1:0]  i_minus_k;

    assign len_full  = (r_len == LEN_W'(MAX_LEN));
    assign i_minus_k = r_i - r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !len_full) begin
            r_mem[r_len[ADDR_W-1:0]] <= i_req.char_in;
        end
        if (i_cmd.rd_issue) begin
            r_rd_a <= r_mem[r_i[ADDR_W-1:0]];
            r_rd_b <= r_mem[i_minus_k[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_issue;
            r_out_vld <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (i_cmd.load) begin
                if (len_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_init) begin
            r_k <= LEN_W'(1);
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + LEN_W'(1);
        end
        if (i_cmd.rem_load) begin
            r_rem <= r_len;
        end else if (i_cmd.rem_sub) begin
            r_rem <= r_rem - r_k;
        end
        if (i_cmd.i_load) begin
            r_i <= r_k;
        end else if (i_cmd.rd_issue) begin
            r_i <= r_i + LEN_W'(1);
        end
        if (i_cmd.emit) begin
            r_result.period   <= PERIOD_W'(r_k);
            r_result.overflow <= r_ovf;
        end
    end

    assign o_sts.k_lt_n   = (r_k < r_len);
    assign o_sts.rem_gt_k = (r_rem > r_k);
    assign o_sts.rem_eq_k = (r_rem == r_k);
    assign o_sts.i_lt_n   = (r_i < r_len);
    assign o_sts.mismatch = r_cmp_vld && (r_rd_a != r_rd_b);

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hdl/ssp_ctrl.sv -----
// Controller: request acceptance and period search sequencing.
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_last,
    input  wire ssp_pkg::t_ssp_sts i_sts,
    output ssp_pkg::t_ssp_cmd      o_cmd,
    output logic                   o_busy
);
    import ssp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.k_init = 1'b1;
                        n_state      = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.k_lt_n) begin
                    o_cmd.rem_load = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DIV: begin
                priority if (i_sts.rem_gt_k) begin
                    o_cmd.rem_sub = 1'b1;
                end else if (i_sts.rem_eq_k) begin
                    o_cmd.i_load = 1'b1;
                    n_state      = S_SCAN;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_SCAN: begin
                priority if (i_sts.mismatch) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_CHECK;
                end else if (i_sts.i_lt_n) begin
                    o_cmd.rd_issue = 1'b1;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ----- hdl/smallest_string_period.sv -----
// Top level of the smallest string period block.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A request (one byte plus last_char flag) is taken on a rising edge with
//   start high and busy low. Bytes that are not last are taken at one per
//   cycle and keep busy low. Up to MAX_LEN bytes are stored; later bytes are
//   dropped and set the overflow flag.
//   After the last byte, busy rises and the search runs over k = 1, 2, ...
//   For each k a repeated subtraction tests k | n; for a divisor, s[i] is
//   compared with s[i-k] at one byte per cycle from the dual-read character
//   store, stopping early on a mismatch. The first accepted divisor ends the
//   search.
//   The result (period, overflow) is held on o_result for one cycle with
//   o_valid high; the receiver cannot stall it. busy falls in that cycle.
//   Reset clears the length, the overflow flag and the controller; the
//   character store is not cleared.

module smallest_string_period (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire ssp_pkg::t_ssp_in i_req,
    output logic                  busy,
    output logic                  o_valid,
    output ssp_pkg::t_ssp_out     o_result
);
    import ssp_pkg::*;

    t_ssp_cmd cmd;
    t_ssp_sts sts;
    logic     accept;

    assign accept = start && !busy;

    ssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_last  (i_req.last_char),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ssp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- dv/smallest_string_period_test.sv -----
// Testbench for smallest_string_period: directed string table, then random strings.
`timescale 1ns / 1ps

module smallest_string_period_test;
    import ssp_pkg::*;

    localparam int LIMIT      = 1000000;
    localparam int RAND_ITEMS = 550;
    localparam int DRAIN      = 64;
    localparam int PAT_MAX    = 160;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                last;
        logic [7:0]          reps;
        logic                typed;
        logic [PERIOD_W-1:0] period;
        logic                ovf;
    } t_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_ssp_in  i_req   = '0;
    logic     busy;
    logic     o_valid;
    t_ssp_out o_result;

    // predictor state
    logic [CHAR_W-1:0] str_bytes [MAX_LEN];
    int                str_len = 0;
    logic              str_ovf = 1'b0;
    t_ssp_out          period_due [$];

    t_row              rows [$];
    logic [CHAR_W-1:0] pend [$];

    int cycles     = 0;
    int mismatches = 0;
    int n_reqs     = 0;
    int n_results  = 0;
    int n_ovf      = 0;
    int n_strings  = 0;

    smallest_string_period i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, period_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int smallest_period(input int n);
        int  k;
        int  i;
        bit  ok;
        for (k = 1; k < n; k++) begin
            if (n % k == 0) begin
                ok = 1'b1;
                for (i = k; i < n; i++)
                    if (str_bytes[i] != str_bytes[i-k])
                        ok = 1'b0;
                if (ok)
                    return k;
            end
        end
        return n;
    endfunction

    task automatic take_byte(input t_ssp_in r, output bit done, output t_ssp_out res);
        int k;
        if (str_len < MAX_LEN) begin
            str_bytes[str_len] = r.char_in;
            str_len++;
        end else begin
            str_ovf = 1'b1;
        end
        done = r.last_char;
        res  = '0;
        if (r.last_char) begin
            k = (str_len == 0) ? 1 : smallest_period(str_len);
            res.period   = k[PERIOD_W-1:0];
            res.overflow = str_ovf;
            str_len = 0;
            str_ovf = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input t_ssp_out want, input t_ssp_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected period %0d ovf %0b, got period %0d ovf %0b",
                     $time, what, want.period, want.overflow, got.period, got.overflow);
    endtask

    always @(posedge i_clk) begin
        t_ssp_out want;
        if (i_rst_n && o_valid === 1'b1) begin
            n_results++;
            if (o_result.overflow === 1'b1)
                n_ovf++;
            if (period_due.size() == 0) begin
                report_mismatch("unexpected result", 'x, o_result);
            end else begin
                want = period_due.pop_front();
                if (o_result.period !== want.period || o_result.overflow !== want.overflow)
                    report_mismatch("wrong result", want, o_result);
            end
        end
    end

    task automatic send_req(input t_ssp_in r, input int idle_pct, input bit typed,
                            input t_ssp_out typed_res);
        int       gap;
        bit       done;
        t_ssp_out res;
        @(negedge i_clk);
        if ($urandom_range(1, 100) <= idle_pct) begin
            start = 1'b0;
            gap   = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_reqs++;
        take_byte(r, done, res);
        if (done) begin
            n_strings++;
            period_due = {period_due, (typed ? typed_res : res)};
        end
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        start = 1'b0;
        while (period_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic last, input int reps,
                           input logic typed, input int period, input logic ovf);
        t_row row;
        row.ch     = ch;
        row.last   = last;
        row.reps   = reps[7:0];
        row.typed  = typed;
        row.period = period[PERIOD_W-1:0];
        row.ovf    = ovf;
        rows = {rows, row};
    endtask

    function automatic int phase_idle(input int ph);
        case (ph)
            1:       return 52;
            3:       return 32;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_char(input int alpha, input logic [7:0] sym [3]);
        if (alpha >= 256)
            return $urandom_range(0, 255);
        return sym[$urandom_range(0, alpha - 1)];
    endfunction

    // periodic strings with random content, some with one flipped bit, some noise
    task automatic make_string();
        int          mode;
        int          p;
        int          n;
        int          i;
        int          alpha;
        logic [7:0]  sym [3];
        logic [7:0]  pat [PAT_MAX];
        logic [7:0]  b;
        pend.delete();
        mode  = $urandom_range(0, 19);
        alpha = $urandom_range(0, 1) ? 256 : $urandom_range(2, 3);
        for (i = 0; i < 3; i++)
            sym[i] = $urandom_range(0, 255);
        if (mode < 12) begin
            p = $urandom_range(1, 8);
            n = p * $urandom_range(1, 6);
        end else if (mode < 16) begin
            n = $urandom_range(1, 20);
            p = n;
        end else if (mode < 18) begin
            n     = $urandom_range(1, 12);
            p     = n;
            alpha = 256;
        end else begin
            p = $urandom_range(0, 1) ? (1 << $urandom_range(0, 6)) : $urandom_range(1, 64);
            n = $urandom_range(100, 140);
            if ($urandom_range(0, 1))
                n = (n / p) * p;
        end
        for (i = 0; i < p; i++)
            pat[i] = pick_char(alpha, sym);
        for (i = 0; i < n; i++)
            pend = {pend, pat[i % p]};
        if (mode < 12 && $urandom_range(0, 3) == 0) begin
            i = $urandom_range(0, n - 1);
            b = pend[i];
            pend[i] = b ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    initial begin
        t_ssp_in  r;
        t_ssp_out typed_res;
        int       ri;
        int       j;
        int       sent;
        int       ph;
        int       new_ph;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(8'h00, 1'b1, 1, 1'b1, 1, 1'b0);
        add_row(8'hFF, 1'b1, 1, 1'b1, 1, 1'b0);
        add_row(8'h61, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h62, 1'b1, 1, 1'b0, 0, 1'b0);
        add_row(8'h61, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h61, 1'b1, 1, 1'b0, 0, 1'b0);
        add_row(8'h7F, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h80, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h7F, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h80, 1'b1, 1, 1'b0, 0, 1'b0);
        add_row(8'h61, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h62, 1'b0, 1, 1'b0, 0, 1'b0);
        add_row(8'h61, 1'b1, 1, 1'b0, 0, 1'b0);
        // full store, no repeat
        add_row(8'hA5, 1'b0, 127, 1'b0, 0, 1'b0);
        add_row(8'h3C, 1'b1, 1, 1'b1, 128, 1'b0);
        // too long, dropped tail
        add_row(8'h5A, 1'b0, 130, 1'b0, 0, 1'b0);
        add_row(8'h5A, 1'b1, 1, 1'b1, 1, 1'b1);
        add_row(8'h78, 1'b0, 128, 1'b0, 0, 1'b0);
        add_row(8'h87, 1'b1, 1, 1'b1, 1, 1'b1);

        for (ri = 0; ri < rows.size(); ri++) begin
            r.char_in          = rows[ri].ch;
            r.last_char        = rows[ri].last;
            typed_res.period   = rows[ri].period;
            typed_res.overflow = rows[ri].ovf;
            for (j = 0; j < rows[ri].reps; j++)
                send_req(r, 0, rows[ri].typed, typed_res);
        end
        wait_results();

        sent = 0;
        ph   = 0;
        while (sent < RAND_ITEMS) begin
            new_ph = (sent * 4) / RAND_ITEMS;
            if (new_ph != ph) begin
                wait_results();
                ph = new_ph;
            end
            make_string();
            for (j = 0; j < pend.size(); j++) begin
                r.char_in   = pend[j];
                r.last_char = (j == pend.size() - 1);
                send_req(r, phase_idle(ph), 1'b0, '0);
                sent++;
            end
        end

        wait_results();
        repeat (DRAIN) @(posedge i_clk);

        $display("%0d requests in %0d strings, %0d results checked, %0d truncated",
                 n_reqs, n_strings, n_results, n_ovf);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- smallest_string_period.f -----
hdl/ssp_pkg.sv
hdl/ssp_datapath.sv
hdl/ssp_ctrl.sv
hdl/smallest_string_period.sv
dv/smallest_string_period_test.sv
